FILE: hdl/nca_pkg.sv
// shared types, constants and helpers for the nearest center assignment block
`timescale 1ns / 1ps

package nca_pkg;

  // block dimensions
  localparam int MAX_CENTERS = 16;
  localparam int DIMS        = 4;
  localparam int COORD_BITS  = 16;

  // fixed field widths of the stream payloads
  localparam int FUNC_W          = 1;
  localparam int SLOT_W          = 4;
  localparam int COORD_FIELD_W   = 16;
  localparam int NEAR_IDX_W      = 4;
  localparam int MIN_DISTANCE_W  = 34;
  localparam int CFG_W           = 5;

  localparam int S_TDATA_BITS = SLOT_W + 4 * COORD_FIELD_W;
  localparam int S_TDATA_W    = ((S_TDATA_BITS + 7) / 8) * 8;
  localparam int M_TDATA_BITS = NEAR_IDX_W + MIN_DISTANCE_W;
  localparam int M_TDATA_W    = ((M_TDATA_BITS + 7) / 8) * 8;

  // internal widths
  localparam int IDX_W   = $clog2(MAX_CENTERS);
  localparam int USED_W  = $clog2(MAX_CENTERS + 1);
  localparam int DIFF_W  = COORD_BITS + 1;
  localparam int SQ_W    = 2 * COORD_BITS;
  localparam int DIST_W  = SQ_W + $clog2(DIMS);
  localparam int LVLS    = IDX_W;
  localparam int NPAD    = 1 << LVLS;
  localparam int LAT     = 3 + LVLS;

  // item kinds carried in tuser
  typedef enum logic [FUNC_W-1:0] {
    FUNC_LOAD     = 1'b0,
    FUNC_CLASSIFY = 1'b1
  } func_e;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef coord_t [DIMS-1:0] point_t;

  // one candidate in the merge tree
  typedef struct packed {
    logic              vld;
    logic [IDX_W-1:0]  idx;
    logic [DIST_W-1:0] sqd;
  } cand_t;

  // lane control from the top level
  typedef struct packed {
    logic                   en;
    logic [MAX_CENTERS-1:0] in_use;
  } lane_ctl_t;

  // keep the left (lower index) candidate unless the right one is strictly closer
  function automatic cand_t pick_closer(input cand_t a, input cand_t b);
    cand_t r;
    r = a;
    if (b.vld && (!a.vld || (b.sqd < a.sqd))) begin
      r = b;
    end
    return r;
  endfunction

endpackage

FILE: hdl/nca_lane.sv
// one distance lane: squared euclidean distance from the point to one center
`timescale 1ns / 1ps

module nca_lane (
  input  logic                  clk_i,
  input  logic                  en_i,
  input  nca_pkg::point_t       point_i,
  input  nca_pkg::point_t       center_i,
  output logic [nca_pkg::DIST_W-1:0] dist_o
);
  import nca_pkg::*;

  logic [SQ_W-1:0]   sq_q [DIMS];
  logic [SQ_W-1:0]   sq_d [DIMS];
  logic [DIST_W-1:0] dist_d;
  logic [DIST_W-1:0] dist_q;

  // per channel difference and square
  always_comb begin
    logic signed [DIFF_W-1:0]   diff;
    logic signed [2*DIFF_W-1:0] prod;
    for (int d = 0; d < DIMS; d++) begin
      diff    = DIFF_W'($signed(point_i[d])) - DIFF_W'($signed(center_i[d]));
      prod    = diff * diff;
      sq_d[d] = prod[SQ_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sq_q <= sq_d;
    end
  end

  // sum of the channel squares
  always_comb begin
    dist_d = '0;
    for (int d = 0; d < DIMS; d++) begin
      dist_d = dist_d + DIST_W'(sq_q[d]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dist_q <= dist_d;
    end
  end

  assign dist_o = dist_q;

endmodule

FILE: hdl/nca_merge.sv
// registered min tree over the lane distances, lowest index wins on ties
`timescale 1ns / 1ps

module nca_merge (
  input  logic                       clk_i,
  input  nca_pkg::lane_ctl_t         ctl_i,
  input  logic [nca_pkg::DIST_W-1:0] dist_i [nca_pkg::MAX_CENTERS],
  output nca_pkg::cand_t             best_o
);
  import nca_pkg::*;

  cand_t leaf [NPAD];
  cand_t node_q [NPAD-1];

  // leaves: one per lane, padding leaves never win
  for (genvar i = 0; i < NPAD; i++) begin : g_leaf
    if (i < MAX_CENTERS) begin : g_used
      assign leaf[i].vld = ctl_i.in_use[i];
      assign leaf[i].idx = IDX_W'(i);
      assign leaf[i].sqd = dist_i[i];
    end else begin : g_pad
      assign leaf[i] = '0;
    end
  end

  // heap-ordered internal nodes, each one register
  for (genvar n = 0; n < NPAD - 1; n++) begin : g_node
    localparam int LC = 2 * n + 1;
    localparam int RC = 2 * n + 2;
    cand_t lc;
    cand_t rc;

    if (LC >= NPAD - 1) begin : g_lleaf
      assign lc = leaf[LC-(NPAD-1)];
    end else begin : g_lnode
      assign lc = node_q[LC];
    end

    if (RC >= NPAD - 1) begin : g_rleaf
      assign rc = leaf[RC-(NPAD-1)];
    end else begin : g_rnode
      assign rc = node_q[RC];
    end

    always_ff @(posedge clk_i) begin
      if (ctl_i.en) begin
        node_q[n] <= pick_closer(lc, rc);
      end
    end
  end

  assign best_o = node_q[0];

endmodule

FILE: hdl/nearest_center_assign.sv
// top level: center store, parallel distance lanes, min merge and output register
//
//  channel  | direction | tdata fields (low bit up)                     | tuser
//  s_axis   | in        | center_slot, coord_0, coord_1, coord_2, coord_3 | func
//  m_axis   | out       | nearest index, min_distance                   | -
//  cfg      | in        | num_centers (valid / ready / data)            | -
//
// one item is taken per cycle while no result waits on m_axis_tready; a classify result
// passes the point register, loaded at its acceptance edge, then the lane square,
// the lane sum, four merge tree levels and the output register. a load takes effect
// at its acceptance edge.
// rst_ni clears control state and sets num_centers to 1; the center store is not cleared.
// when a result waits on m_axis_tready the whole pipeline holds and s_axis_tready drops.
`timescale 1ns / 1ps

module nearest_center_assign (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // center_slot[3:0], coord_0[19:4], coord_1[35:20], coord_2[51:36], coord_3[67:52]
  input  logic [nca_pkg::S_TDATA_W-1:0] s_axis_tdata,
  // func[0]
  input  logic [nca_pkg::FUNC_W-1:0]    s_axis_tuser,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // nearest index[3:0], min_distance[37:4]
  output logic [nca_pkg::M_TDATA_W-1:0] m_axis_tdata,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [nca_pkg::CFG_W-1:0]     cfg_data_i
);
  import nca_pkg::*;

  logic              adv;
  logic              acc;
  logic [SLOT_W-1:0] slot;
  point_t            pt_in;
  point_t            pt_q;
  point_t            center_q [MAX_CENTERS];
  logic [USED_W-1:0] used_q;
  logic [USED_W-1:0] used_d;
  logic [LAT-1:0]    vld_q;
  lane_ctl_t         ctl;
  logic [DIST_W-1:0] lane_sqd [MAX_CENTERS];
  cand_t             best;
  logic              out_valid_q;
  logic [IDX_W-1:0]  out_idx_q;
  logic [DIST_W-1:0] out_dist_q;

  // pipeline moves unless a result is held at the output
  assign adv           = !out_valid_q || m_axis_tready;
  assign s_axis_tready = adv;
  assign acc           = s_axis_tvalid && adv;

  // unpack the input payload
  assign slot = s_axis_tdata[SLOT_W-1:0];
  always_comb begin
    for (int d = 0; d < DIMS; d++) begin
      pt_in[d] = s_axis_tdata[SLOT_W + d*COORD_FIELD_W +: COORD_BITS];
    end
  end

  // configuration register, held in clamped form
  assign cfg_ready_o = 1'b1;
  always_comb begin
    if (cfg_data_i == '0) begin
      used_d = USED_W'(1);
    end else if (int'(cfg_data_i) > MAX_CENTERS) begin
      used_d = USED_W'(MAX_CENTERS);
    end else begin
      used_d = USED_W'(cfg_data_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q <= USED_W'(1);
    end else if (cfg_valid_i) begin
      used_q <= used_d;
    end
  end

  // center store, written by load transactions
  always_ff @(posedge clk_i) begin
    if (acc && (func_e'(s_axis_tuser) == FUNC_LOAD) && (int'(slot) < MAX_CENTERS)) begin
      center_q[IDX_W'(slot)] <= pt_in;
    end
  end

  // point register feeding the lanes
  always_ff @(posedge clk_i) begin
    if (adv) begin
      pt_q <= pt_in;
    end
  end

  // classify valid pipeline
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[LAT-2:0], acc && (func_e'(s_axis_tuser) == FUNC_CLASSIFY)};
    end
  end

  // lane control
  always_comb begin
    ctl.en = adv;
    for (int c = 0; c < MAX_CENTERS; c++) begin
      ctl.in_use[c] = USED_W'(c) < used_q;
    end
  end

  // one lane per center
  for (genvar c = 0; c < MAX_CENTERS; c++) begin : g_lane
    nca_lane u_lane (
      .clk_i    (clk_i),
      .en_i     (ctl.en),
      .point_i  (pt_q),
      .center_i (center_q[c]),
      .dist_o   (lane_sqd[c])
    );
  end

  nca_merge u_merge (
    .clk_i  (clk_i),
    .ctl_i  (ctl),
    .dist_i (lane_sqd),
    .best_o (best)
  );

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= vld_q[LAT-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_idx_q  <= best.idx;
      out_dist_q <= best.sqd;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = M_TDATA_W'({MIN_DISTANCE_W'(out_dist_q),
                                     NEAR_IDX_W'(out_idx_q)});

endmodule
